/* hdl/rse_pkg.sv */
// Shared constants and GF(2^8) arithmetic for the Reed-Solomon encoder.
`timescale 1ns / 1ps

package rse_pkg;

    // Largest generator degree the datapath holds.
    localparam int MAX_PARITY = 32;

    localparam int SYM_W   = 8;
    localparam int NPAR_W  = $clog2(MAX_PARITY + 1);
    localparam int CNT_W   = 9;
    localparam int CFG_W   = 8;

    // Configuration register indexes.
    localparam logic REG_PARITY_COUNT = 1'b0;
    localparam logic REG_FIELD_POLY   = 1'b1;

    localparam logic [5:0]       PARITY_COUNT_RST = 6'd10;
    localparam logic [SYM_W-1:0] FIELD_POLY_RST   = 8'h1D;

    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [CNT_W:0]   CODE_LEN_MAX = 10'd255;

    // Shift-and-add product in GF(2^8); poly holds the low eight bits of the
    // reduction polynomial with bit 8 implied.
    function automatic logic [SYM_W-1:0] gf_mul(
        input logic [SYM_W-1:0] a,
        input logic [SYM_W-1:0] b,
        input logic [SYM_W-1:0] poly
    );
        logic [SYM_W-1:0] acc;
        logic [SYM_W-1:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? poly : '0);
        end
        return acc;
    endfunction

    // Parity count as used by the datapath: zero reads as one, and anything
    // above the register file depth reads as the depth.
    function automatic logic [NPAR_W-1:0] clamp_parity(input logic [5:0] pc);
        logic [NPAR_W-1:0] n;
        if (pc == 6'd0) begin
            n = NPAR_W'(1);
        end else if (pc > 6'(MAX_PARITY)) begin
            n = NPAR_W'(MAX_PARITY);
        end else begin
            n = NPAR_W'(pc);
        end
        return n;
    endfunction

endpackage

/* hdl/reed_solomon_systematic_encoder.sv */
// Top level of the systematic Reed-Solomon encoder over GF(2^8).
`timescale 1ns / 1ps
//
//  Channel   | Direction | Payload
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tdata = message_byte, tlast = message_last
//  m_axis    | out       | tdata = code_byte, tlast = code_last,
//            |           | tuser = too_long
//  cfg       | in        | index 0 = parity_count, index 1 = field_poly_low
//
//  Each message byte is loaded into the output register as it is accepted
//  and appears on the output in the following cycle; the n parity bytes then
//  drain from the parity register at one per cycle while the output is not
//  stalled, during which the input is held off.
//  After reset and after every configuration write the generator polynomial
//  is rebuilt by a sequencer that multiplies in one root per cycle, and the
//  input stays not ready until the build has finished.
//  A stall on the output holds the output register; the input then waits.
//  Reset is synchronous and active low.

module reed_solomon_systematic_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] message_byte
    input  logic       i_s_axis_tlast,

    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] code_byte
    output logic       o_m_axis_tlast,
    output logic       o_m_axis_tuser,   // [0] too_long

    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wr_data
);

    localparam int MP = rse_pkg::MAX_PARITY;
    localparam int SW = rse_pkg::SYM_W;
    localparam int NW = rse_pkg::NPAR_W;
    localparam int CW = rse_pkg::CNT_W;

    // Configuration registers.
    logic [5:0]    r_parity_count;
    logic [SW-1:0] r_field_poly;

    // Generator build sequencer. r_gen[j] holds coefficient j+1 of the monic
    // generator, highest first; coefficients above the degree stay zero.
    logic          r_bld_busy;
    logic [NW-1:0] r_bld_cnt;
    logic [SW-1:0] r_root;
    logic [SW-1:0] r_gen [MP];
    logic [NW-1:0] r_n;

    // Remainder shift register and message symbol count.
    logic [SW-1:0] r_rem [MP];
    logic [CW-1:0] r_sym_cnt;

    // Parity bytes waiting to leave, and how many remain.
    logic [SW-1:0] r_par [MP];
    logic [NW-1:0] r_par_cnt;
    logic          r_par_flag;

    // Output register.
    logic          r_out_valid;
    logic [SW-1:0] r_out_byte;
    logic          r_out_last;
    logic          r_out_flag;

    logic [NW-1:0] n_clamp;
    logic [SW-1:0] n_gen [MP];
    logic [SW-1:0] n_rem [MP];
    logic [SW-1:0] n_fb;
    logic [CW-1:0] n_sym_cnt;
    logic          n_flag;
    logic          n_out_free;
    logic          n_in_acc;

    assign n_clamp = rse_pkg::clamp_parity(r_parity_count);

    // One step of the generator build: multiply the polynomial by (x + root).
    always_comb begin
        n_gen[0] = r_gen[0] ^ rse_pkg::gf_mul(8'h01, r_root, r_field_poly);
        for (int j = 1; j < MP; j++) begin
            n_gen[j] = r_gen[j] ^ rse_pkg::gf_mul(r_gen[j-1], r_root, r_field_poly);
        end
    end

    // Remainder update for one message byte. Entries at or above the degree
    // hold zero, so the top entry simply shifts in zero.
    assign n_fb = i_s_axis_tdata ^ r_rem[0];

    always_comb begin
        for (int j = 0; j < MP - 1; j++) begin
            n_rem[j] = r_rem[j+1] ^ rse_pkg::gf_mul(n_fb, r_gen[j], r_field_poly);
        end
        n_rem[MP-1] = rse_pkg::gf_mul(n_fb, r_gen[MP-1], r_field_poly);
    end

    // The symbol count saturates; the flag compares count plus degree to 255.
    assign n_sym_cnt = (r_sym_cnt == rse_pkg::CNT_MAX) ? r_sym_cnt : CW'(r_sym_cnt + 1'b1);
    assign n_flag    = ({1'b0, n_sym_cnt} + (CW + 1)'(r_n)) > rse_pkg::CODE_LEN_MAX;

    assign n_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = n_out_free && (r_par_cnt == '0) && !r_bld_busy;
    assign n_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_count <= rse_pkg::PARITY_COUNT_RST;
            r_field_poly   <= rse_pkg::FIELD_POLY_RST;
            r_bld_busy     <= 1'b1;
            r_bld_cnt      <= '0;
            r_root         <= 8'h01;
            r_n            <= rse_pkg::clamp_parity(rse_pkg::PARITY_COUNT_RST);
            r_sym_cnt      <= '0;
            r_par_cnt      <= '0;
            r_out_valid    <= 1'b0;
            for (int j = 0; j < MP; j++) begin
                r_gen[j] <= '0;
                r_rem[j] <= '0;
            end
        end else begin
            // Any configuration write restarts the generator build.
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    rse_pkg::REG_PARITY_COUNT: r_parity_count <= i_cfg_wr_data[5:0];
                    rse_pkg::REG_FIELD_POLY:   r_field_poly   <= i_cfg_wr_data;
                    default:                   r_field_poly   <= r_field_poly;
                endcase
                r_bld_busy <= 1'b1;
                r_bld_cnt  <= '0;
                r_root     <= 8'h01;
                for (int j = 0; j < MP; j++) begin
                    r_gen[j] <= '0;
                end
            end else if (r_bld_busy) begin
                if (r_bld_cnt == n_clamp) begin
                    r_bld_busy <= 1'b0;
                    r_n        <= n_clamp;
                end else begin
                    r_gen     <= n_gen;
                    r_root    <= rse_pkg::gf_mul(r_root, 8'h02, r_field_poly);
                    r_bld_cnt <= NW'(r_bld_cnt + 1'b1);
                end
            end

            // Output register: pending parity bytes go first, otherwise the
            // message byte accepted in this cycle.
            if (n_out_free) begin
                if (r_par_cnt != '0) begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= r_par[0];
                    r_out_last  <= (r_par_cnt == NW'(1));
                    r_out_flag  <= r_par_flag;
                    r_par_cnt   <= NW'(r_par_cnt - 1'b1);
                end else if (n_in_acc) begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= i_s_axis_tdata;
                    r_out_last  <= 1'b0;
                    r_out_flag  <= n_flag;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end

            if (n_in_acc) begin
                if (i_s_axis_tlast) begin
                    // Hand the finished remainder to the parity register and
                    // start the next message from a clear state.
                    r_par_cnt  <= r_n;
                    r_par_flag <= n_flag;
                    r_sym_cnt  <= '0;
                    for (int j = 0; j < MP; j++) begin
                        r_rem[j] <= '0;
                    end
                end else begin
                    r_rem     <= n_rem;
                    r_sym_cnt <= n_sym_cnt;
                end
            end
        end
    end

    // Parity shift register; the load on a last byte wins over the drain,
    // which cannot happen in the same cycle.
    always_ff @(posedge i_clk) begin
        if (n_in_acc && i_s_axis_tlast) begin
            r_par <= n_rem;
        end else if (n_out_free && (r_par_cnt != '0)) begin
            for (int j = 0; j < MP - 1; j++) begin
                r_par[j] <= r_par[j+1];
            end
            r_par[MP-1] <= '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_flag;

endmodule

/* hdl/rse_checker.sv */
// Port-level checker for the Reed-Solomon encoder, with its bind.
`timescale 1ns / 1ps

module rse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       o_m_axis_tuser,
    input logic       i_cfg_wr_en
);

    // A stalled output item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

    // Reset starts a generator build, so the input cannot be ready right after.
    a_reset_build: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready directly after reset");

    // A configuration write starts a rebuild that holds off the input.
    a_cfg_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !o_s_axis_tready)
        else $error("input ready directly after a configuration write");

    // A last message byte leaves at least one parity byte to send first.
    a_last_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input ready while parity bytes are pending");

endmodule

bind reed_solomon_systematic_encoder rse_checker u_rse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .i_cfg_wr_en     (i_cfg_wr_en)
);

/* bench/tb_reed_solomon_systematic_encoder.sv */
// Self-checking testbench for the systematic Reed-Solomon encoder.
`timescale 1ns / 1ps

module tb_reed_solomon_systematic_encoder;

    // Cycles without any handshake or register write before the run is abandoned.
    // The slowest legal wait is a generator rebuild plus a full sender gap
    // and a full receiver stall, far below this.
    localparam int WATCHDOG_LIMIT = 3000;
    // Quiet cycles granted after the last expected item before a register write.
    localparam int SETTLE_CYCLES  = 4;
    // Cycles watched at the end for stray output items.
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_ITEMS   = 40;

    // One codeword symbol as it leaves the master side.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       code_last;
        logic       too_long;
    } code_sym_t;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       in_valid      = 1'b0;
    logic [7:0] in_data       = 8'h00;
    logic       in_last       = 1'b0;
    logic       out_ready     = 1'b0;
    logic       cfg_we        = 1'b0;
    logic       cfg_idx       = rse_pkg::REG_PARITY_COUNT;
    logic [7:0] cfg_data      = 8'h00;

    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic       o_m_axis_tuser;

    // Idling switches; each side draws a fresh wait per item while its switch is on.
    bit stall_in  = 1'b1;
    bit stall_out = 1'b1;

    // Mirror of the configuration registers as last written.
    logic [5:0] parity_reg;
    logic [7:0] poly_reg;

    // Encoder state as the bench expects it to be.
    logic [7:0]  gen_coef [rse_pkg::MAX_PARITY];
    logic [7:0]  parity_sr [rse_pkg::MAX_PARITY];
    int unsigned msg_symbols;
    int unsigned cw_parity;

    code_sym_t code_expected [$];

    int errors        = 0;
    int items_sent    = 0;
    int messages_sent = 0;
    int codes_seen    = 0;
    int flagged_seen  = 0;
    int reg_writes    = 0;
    int idle_cycles   = 0;

    reed_solomon_systematic_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tlast  (in_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_wr_data   (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Expected behavior
    // ------------------------------------------------------------------

    // GF(2^8) product computed MSB-first (Horner form): double the running
    // sum, reduce with the programmed polynomial, then add b when a's bit is set.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 7; k >= 0; k--) begin
            acc = acc[7] ? ({acc[6:0], 1'b0} ^ poly_reg) : {acc[6:0], 1'b0};
            if (a[k]) begin
                acc = acc ^ b;
            end
        end
        return acc;
    endfunction

    // Latch the parity count for a new codeword and expand the product of
    // (x + 2^i) for i below it. The monic leading term is dropped.
    function automatic void build_generator_poly();
        logic [7:0] g [rse_pkg::MAX_PARITY + 1];
        logic [7:0] root;
        if (parity_reg == 6'd0) begin
            cw_parity = 1;
        end else if (parity_reg > rse_pkg::MAX_PARITY) begin
            cw_parity = rse_pkg::MAX_PARITY;
        end else begin
            cw_parity = parity_reg;
        end
        foreach (g[j]) begin
            g[j] = 8'h00;
        end
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < cw_parity; i++) begin
            for (int j = i + 1; j >= 1; j--) begin
                g[j] = g[j] ^ gf_times(g[j-1], root);
            end
            root = gf_times(root, 8'h02);
        end
        for (int j = 0; j < rse_pkg::MAX_PARITY; j++) begin
            gen_coef[j] = (j < cw_parity) ? g[j+1] : 8'h00;
        end
    endfunction

    // Advance the expected encoder by one accepted message byte and queue the
    // codeword symbols it produces: the byte itself, plus the parity on the last.
    function automatic void encode_symbol(input logic [7:0] m, input logic last);
        logic [7:0] fb;
        logic       flag;
        code_sym_t  sym;
        if (msg_symbols == 0) begin
            build_generator_poly();
            foreach (parity_sr[j]) begin
                parity_sr[j] = 8'h00;
            end
        end
        // The symbol counter is nine bits wide and sticks at its top value.
        if (msg_symbols < 511) begin
            msg_symbols++;
        end
        flag = (msg_symbols + cw_parity > 255);

        fb = m ^ parity_sr[0];
        for (int j = 0; j + 1 < cw_parity; j++) begin
            parity_sr[j] = parity_sr[j+1] ^ gf_times(fb, gen_coef[j]);
        end
        parity_sr[cw_parity-1] = gf_times(fb, gen_coef[cw_parity-1]);

        sym.code_byte = m;
        sym.code_last = 1'b0;
        sym.too_long  = flag;
        code_expected.push_back(sym);

        if (last) begin
            for (int j = 0; j < cw_parity; j++) begin
                sym.code_byte = parity_sr[j];
                sym.code_last = (j + 1 == cw_parity);
                sym.too_long  = flag;
                code_expected.push_back(sym);
            end
            foreach (parity_sr[j]) begin
                parity_sr[j] = 8'h00;
            end
            msg_symbols = 0;
            messages_sent++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one message byte. The task returns right after the accepting edge
    // with tvalid still high, so back-to-back items never drop tvalid; the
    // next call either keeps it up or lowers it at the following falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = stall_in ? $urandom_range(0, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_last  <= last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        encode_symbol(b, last);
        items_sent++;
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (code_expected.size() != 0) @(posedge i_clk);
    endtask

    // Send a whole message of random bytes with tlast on the final one.
    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // Registers change only while the encoder is idle: input held off, every
    // expected item received, and a few quiet cycles on top.
    task automatic write_reg(input logic idx, input logic [7:0] data);
        stop_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == rse_pkg::REG_PARITY_COUNT) begin
            parity_reg = data[5:0];
        end else begin
            poly_reg = data;
        end
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: draws a stall per item, then holds tready until it is taken.
    // ------------------------------------------------------------------
    initial begin : master_ready
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = stall_out ? $urandom_range(0, 12) : 0;
            @(negedge i_clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid === 1'b1 && out_ready));
        end
    end

    // ------------------------------------------------------------------
    // Checker: every output item is matched against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_code
        code_sym_t want;
        if (i_rst_n && out_ready && o_m_axis_tvalid === 1'b1) begin
            codes_seen++;
            if (o_m_axis_tuser === 1'b1) begin
                flagged_seen++;
            end
            if (code_expected.size() == 0) begin
                $error("unexpected output item: code_byte=%02h code_last=%0b too_long=%0b",
                       o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                errors++;
            end else begin
                want = code_expected.pop_front();
                if (o_m_axis_tdata !== want.code_byte) begin
                    $error("code_byte mismatch: expected %02h, actual %02h",
                           want.code_byte, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tlast !== want.code_last) begin
                    $error("code_last mismatch: expected %0b, actual %0b",
                           want.code_last, o_m_axis_tlast);
                    errors++;
                end
                if (o_m_axis_tuser !== want.too_long) begin
                    $error("too_long mismatch: expected %0b, actual %0b",
                           want.too_long, o_m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any handshake or register write restarts the count.
    always @(posedge i_clk) begin
        if ((in_valid && o_s_axis_tready === 1'b1) ||
            (out_ready && o_m_axis_tvalid === 1'b1) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (ten parity bytes, polynomial 0x11D) with byte extremes
    // and a message that is only one byte long.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hA5, 1'b1);
    endtask

    // Register extremes, each followed by a short message. Parity count zero
    // reads as one and anything above the depth reads as the depth; the upper
    // data bits beyond the six-bit register are set to show they are dropped.
    // Polynomial values include degenerate and non-primitive ones.
    task automatic test_config_extremes();
        write_reg(rse_pkg::REG_PARITY_COUNT, 8'hC0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_reg(rse_pkg::REG_PARITY_COUNT, 8'hFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3C, 1'b1);
        write_reg(rse_pkg::REG_PARITY_COUNT, 8'h21);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h81, 1'b1);
        write_reg(rse_pkg::REG_PARITY_COUNT, 8'd32);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h01, 1'b1);
        write_reg(rse_pkg::REG_FIELD_POLY, 8'h00);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b1);
        write_reg(rse_pkg::REG_FIELD_POLY, 8'hFF);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        write_reg(rse_pkg::REG_FIELD_POLY, 8'h2B);
        send_byte(8'h12, 1'b0);
        send_byte(8'hED, 1'b1);
        write_reg(rse_pkg::REG_PARITY_COUNT, 8'd1);
        write_reg(rse_pkg::REG_FIELD_POLY, rse_pkg::FIELD_POLY_RST);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // The sender holds off in the middle of messages and between them until
    // every expected item has come back, so the encoder runs fully empty.
    task automatic test_drain_pause();
        write_reg(rse_pkg::REG_PARITY_COUNT, 8'd8);
        for (int msg = 0; msg < 3; msg++) begin
            for (int k = 0; k < 6; k++) begin
                if (k == 3) begin
                    stop_input();
                    wait_drained();
                end
                send_byte(8'($urandom_range(0, 255)), k == 5);
            end
            stop_input();
            wait_drained();
        end
    endtask

    // One codeword of 224 message bytes at full parity depth: the first 223
    // bytes still fit a 255-symbol codeword and stay unflagged, while the
    // final byte and all of its parity bytes raise too_long.
    task automatic test_long_codeword();
        write_reg(rse_pkg::REG_PARITY_COUNT, 8'd32);
        write_reg(rse_pkg::REG_FIELD_POLY, rse_pkg::FIELD_POLY_RST);
        stall_in  = 1'b0;
        stall_out = 1'b0;
        send_message(224);
        stall_in  = 1'b1;
        stall_out = 1'b1;
    endtask

    // Random messages with random settings between them, and idling switched
    // per message so some stretches run with no gaps at all.
    task automatic test_random_messages();
        int target;
        int len;
        logic [7:0] val;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: val = 8'($urandom_range(0, 255));
                    1: val = {2'($urandom_range(0, 3)), 6'd0};
                    2: val = {2'($urandom_range(0, 3)), 6'd63};
                    default: val = 8'($urandom_range(1, rse_pkg::MAX_PARITY));
                endcase
                write_reg(rse_pkg::REG_PARITY_COUNT, val);
            end
            if ($urandom_range(0, 2) == 0) begin
                val = ($urandom_range(0, 1) == 0) ? rse_pkg::FIELD_POLY_RST
                                                   : 8'($urandom_range(0, 255));
                write_reg(rse_pkg::REG_FIELD_POLY, val);
            end
            stall_in  = ($urandom_range(0, 3) != 0);
            stall_out = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
            send_message(len);
        end
        stall_in  = 1'b1;
        stall_out = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        parity_reg  = rse_pkg::PARITY_COUNT_RST;
        poly_reg    = rse_pkg::FIELD_POLY_RST;
        msg_symbols = 0;
        cw_parity   = 1;
        foreach (parity_sr[j]) begin
            parity_sr[j] = 8'h00;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_drain_pause();
        test_long_codeword();
        test_random_messages();

        stop_input();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Encoded %0d messages (%0d input items) under %0d register writes.",
                 messages_sent, items_sent, reg_writes);
        $display("Checked %0d codeword symbols, %0d of them flagged as too long.",
                 codes_seen, flagged_seen);
        if (errors == 0 && code_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (code_expected.size() != 0) begin
                $error("%0d expected output items never arrived", code_expected.size());
            end
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/rse_pkg.sv
hdl/reed_solomon_systematic_encoder.sv
hdl/rse_checker.sv
bench/tb_reed_solomon_systematic_encoder.sv
